>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// When the condition holds, the consequence holds at the next clock edge.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(name, clk, rst, expr)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

>>> rtl/segx_pkg.sv
// ----------------------------------------------------------------------------
// segx_pkg
// Types and constants of the segment intersection test.
// ----------------------------------------------------------------------------
package segx_pkg;

   // Width and reset value of the orientation tolerance register.
   localparam int unsigned TOL_BITS      = 32;
   localparam logic [TOL_BITS-1:0] TOL_RESET = 32'd107374;

   // Byte address width of the register port.
   localparam int unsigned CSR_ADDR_BITS = 3;

   // Register index, taken from the word address.
   typedef enum logic [0:0] {
      REG_ORIENT_TOL = 1'b0
   } csr_reg_type;

   // Orientation sign of one cross product: both clear means collinear within the tolerance.
   typedef struct packed {
      logic pos;
      logic neg;
   } orient_sign_type;

endpackage

>>> rtl/segment_intersection_test.sv
// ----------------------------------------------------------------------------
// segment_intersection_test: rsp_valid rises once an item has passed through
// the four register stages (diff, mult, sub, cmp), in that order.
// Throughput one item per cycle while rsp_stall is low; a result stall holds
// the last stage, and earlier stages only move up into empty slots.
// Synchronous reset empties the pipeline and loads the default tolerance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_intersection_test #(
   parameter int unsigned COORD_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_BITS-1:0]          req_ax,
   input  logic signed [COORD_BITS-1:0]          req_ay,
   input  logic signed [COORD_BITS-1:0]          req_bx,
   input  logic signed [COORD_BITS-1:0]          req_by,
   input  logic signed [COORD_BITS-1:0]          req_cx,
   input  logic signed [COORD_BITS-1:0]          req_cy,
   input  logic signed [COORD_BITS-1:0]          req_dx,
   input  logic signed [COORD_BITS-1:0]          req_dy,
   // Result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_intersects,
   // Register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [segx_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [segx_pkg::TOL_BITS-1:0]         csr_pwdata,
   output logic [segx_pkg::TOL_BITS-1:0]         csr_prdata,
   output logic                                  csr_pready
);
   import segx_pkg::*;

   localparam int unsigned CB   = COORD_BITS;
   localparam int unsigned DW   = CB + 1;          // coordinate difference
   localparam int unsigned MW   = 2 * DW;          // product
   localparam int unsigned PW   = MW + 1;          // cross product
   localparam int unsigned CMPW = (PW > TOL_BITS + 1) ? PW + 1 : TOL_BITS + 2;

   // Difference slots.
   localparam int unsigned D_ABX = 0;
   localparam int unsigned D_ABY = 1;
   localparam int unsigned D_CAX = 2;
   localparam int unsigned D_CAY = 3;
   localparam int unsigned D_DAX = 4;
   localparam int unsigned D_DAY = 5;
   localparam int unsigned D_CDX = 6;
   localparam int unsigned D_CDY = 7;
   localparam int unsigned D_ACX = 8;
   localparam int unsigned D_ACY = 9;
   localparam int unsigned D_BCX = 10;
   localparam int unsigned D_BCY = 11;
   localparam int unsigned NDIF  = 12;

   // ---------------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------------
   logic [TOL_BITS-1:0] tol_ff;
   logic [TOL_BITS-1:0] tol_in;
   logic                csr_wr;
   logic                csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_reg_type'(csr_paddr[2]) == REG_ORIENT_TOL);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign tol_in     = (csr_wr && csr_hit) ? csr_pwdata : tol_ff;
   assign csr_prdata = csr_hit ? tol_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline flow control: a stage loads when empty or when it drains.
   // ---------------------------------------------------------------------
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

   assign s4_rdy    = !s4_vld_ff || !rsp_stall;
   assign s3_rdy    = !s3_vld_ff || s4_rdy;
   assign s2_rdy    = !s2_vld_ff || s3_rdy;
   assign s1_rdy    = !s1_vld_ff || s2_rdy;
   assign req_stall = !s1_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         if (s1_rdy) begin
            s1_vld_ff <= req_valid;
         end
         if (s2_rdy) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (s3_rdy) begin
            s3_vld_ff <= s2_vld_ff;
         end
         if (s4_rdy) begin
            s4_vld_ff <= s3_vld_ff;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: coordinate differences and segment extents.
   // ---------------------------------------------------------------------
   logic signed [DW-1:0] dif_in [NDIF];
   logic signed [DW-1:0] s1_dif_ff [NDIF];
   logic signed [CB-1:0] ext_in [8];       // ab xlo/xhi/ylo/yhi, cd same
   logic signed [CB-1:0] s1_ext_ff [8];

   function automatic logic signed [DW-1:0] sub_ext(input logic signed [CB-1:0] a,
                                                    input logic signed [CB-1:0] b);
      logic signed [DW-1:0] ae;
      logic signed [DW-1:0] be;
      ae = DW'(a);
      be = DW'(b);
      return ae - be;
   endfunction

   always_comb begin
      dif_in[D_ABX] = sub_ext(req_bx, req_ax);
      dif_in[D_ABY] = sub_ext(req_by, req_ay);
      dif_in[D_CAX] = sub_ext(req_cx, req_ax);
      dif_in[D_CAY] = sub_ext(req_cy, req_ay);
      dif_in[D_DAX] = sub_ext(req_dx, req_ax);
      dif_in[D_DAY] = sub_ext(req_dy, req_ay);
      dif_in[D_CDX] = sub_ext(req_dx, req_cx);
      dif_in[D_CDY] = sub_ext(req_dy, req_cy);
      dif_in[D_ACX] = sub_ext(req_ax, req_cx);
      dif_in[D_ACY] = sub_ext(req_ay, req_cy);
      dif_in[D_BCX] = sub_ext(req_bx, req_cx);
      dif_in[D_BCY] = sub_ext(req_by, req_cy);
      // Sorted ends of each segment along each axis.
      ext_in[0] = (req_ax < req_bx) ? req_ax : req_bx;
      ext_in[1] = (req_ax < req_bx) ? req_bx : req_ax;
      ext_in[2] = (req_ay < req_by) ? req_ay : req_by;
      ext_in[3] = (req_ay < req_by) ? req_by : req_ay;
      ext_in[4] = (req_cx < req_dx) ? req_cx : req_dx;
      ext_in[5] = (req_cx < req_dx) ? req_dx : req_cx;
      ext_in[6] = (req_cy < req_dy) ? req_cy : req_dy;
      ext_in[7] = (req_cy < req_dy) ? req_dy : req_cy;
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_dif_ff <= dif_in;
         s1_ext_ff <= ext_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: eight products and the extent overlap check.
   // ---------------------------------------------------------------------
   logic signed [MW-1:0] prd_in [8];
   logic signed [MW-1:0] s2_prd_ff [8];
   logic                 ovl_in;
   logic                 s2_ovl_ff;

   always_comb begin
      prd_in[0] = MW'(s1_dif_ff[D_ABX]) * MW'(s1_dif_ff[D_CAY]);
      prd_in[1] = MW'(s1_dif_ff[D_ABY]) * MW'(s1_dif_ff[D_CAX]);
      prd_in[2] = MW'(s1_dif_ff[D_ABX]) * MW'(s1_dif_ff[D_DAY]);
      prd_in[3] = MW'(s1_dif_ff[D_ABY]) * MW'(s1_dif_ff[D_DAX]);
      prd_in[4] = MW'(s1_dif_ff[D_CDX]) * MW'(s1_dif_ff[D_ACY]);
      prd_in[5] = MW'(s1_dif_ff[D_CDY]) * MW'(s1_dif_ff[D_ACX]);
      prd_in[6] = MW'(s1_dif_ff[D_CDX]) * MW'(s1_dif_ff[D_BCY]);
      prd_in[7] = MW'(s1_dif_ff[D_CDY]) * MW'(s1_dif_ff[D_BCX]);
      // Extents overlap unless one lies wholly below the other on an axis.
      ovl_in = !(s1_ext_ff[1] < s1_ext_ff[4]) && !(s1_ext_ff[5] < s1_ext_ff[0])
            && !(s1_ext_ff[3] < s1_ext_ff[6]) && !(s1_ext_ff[7] < s1_ext_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         s2_prd_ff <= prd_in;
         s2_ovl_ff <= ovl_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: the four cross products, exact.
   // ---------------------------------------------------------------------
   logic signed [PW-1:0] crs_in [4];
   logic signed [PW-1:0] s3_crs_ff [4];
   logic                 s3_ovl_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         crs_in[i] = PW'(s2_prd_ff[2*i]) - PW'(s2_prd_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (s3_rdy) begin
         s3_crs_ff <= crs_in;
         s3_ovl_ff <= s2_ovl_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: signs against the tolerance band and the final decision.
   // ---------------------------------------------------------------------
   logic signed [CMPW-1:0] tol_pos;
   logic signed [CMPW-1:0] tol_neg;
   orient_sign_type        sgn [4];
   logic                   hit_in;
   logic                   s4_hit_ff;

   always_comb begin
      tol_pos = $signed({{(CMPW-TOL_BITS){1'b0}}, tol_ff});
      tol_neg = -tol_pos;
      for (int i = 0; i < 4; i++) begin
         sgn[i].pos = CMPW'(s3_crs_ff[i]) > tol_pos;
         sgn[i].neg = CMPW'(s3_crs_ff[i]) < tol_neg;
      end
      // Each segment must not see both ends of the other strictly on one side.
      hit_in = s3_ovl_ff
            && !((sgn[0].pos && sgn[1].pos) || (sgn[0].neg && sgn[1].neg))
            && !((sgn[2].pos && sgn[3].pos) || (sgn[2].neg && sgn[3].neg));
   end

   always_ff @(posedge clock) begin
      if (s4_rdy) begin
         s4_hit_ff <= hit_in;
      end
   end

   assign rsp_valid      = s4_vld_ff;
   assign rsp_intersects = s4_hit_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `ASSERT_ALWAYS(a_empty_accepts, clock, reset,
      (s1_vld_ff || s2_vld_ff || s3_vld_ff || s4_vld_ff) || !req_stall)
   `ASSERT_NEXT(a_s1_holds, clock, reset, s1_vld_ff && !s2_rdy, s1_vld_ff)
   `ASSERT_NEXT(a_s3_holds, clock, reset, s3_vld_ff && !s4_rdy, s3_vld_ff)
   `ASSERT_NEXT(a_s3_moves, clock, reset, s3_vld_ff && s4_rdy, s4_vld_ff)

endmodule
